@@ design/s5hp_pkg.sv @@
// Shared types and constants for the SOCKS5 handshake parser.
// No dependencies; used by the result and configuration interfaces and the top level.
package s5hp_pkg;

	localparam int PREF_SLOTS_DEF = 4;
	localparam int MAX_SLOTS      = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int COUNT_W    = 3;
	localparam int METHOD_W   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PREF_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREF_METHOD_0 = 3'd1;

	localparam logic [7:0] SOCKS_VERSION = 8'h05;
	localparam logic [7:0] NO_METHOD     = 8'hff;
	localparam logic [7:0] METHOD_NOAUTH = 8'h00;
	localparam logic [7:0] ATYP_IPV4     = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
	localparam logic [7:0] ATYP_IPV6     = 8'h04;
	localparam logic [7:0] IPV4_LEN      = 8'd4;
	localparam logic [7:0] IPV6_LEN      = 8'd16;

	typedef enum logic [3:0] {
		EV_CONSUMED    = 4'd0,
		EV_REPLY_CONT  = 4'd1,
		EV_REPLY_CLOSE = 4'd2,
		EV_REFUSED     = 4'd3,
		EV_BAD_VER     = 4'd4,
		EV_BAD_ATYP    = 4'd5,
		EV_ADDR        = 4'd6,
		EV_DONE        = 4'd7,
		EV_IGNORED     = 4'd8
	} event_t;

endpackage

@@ design/s5hp_byte_if.sv @@
// Received byte channel: valid/ready handshake carrying one word of stream data.
// Depends on nothing.
interface s5hp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ design/s5hp_res_if.sv @@
// Result channel: one word per received byte with the parse event and captured fields.
// Depends on s5hp_pkg.
interface s5hp_res_if;
	import s5hp_pkg::*;

	logic        valid;
	logic        ready;
	event_t      event_res;
	logic [7:0]  reply_method;
	logic [7:0]  command;
	logic [7:0]  address_type;
	logic [7:0]  address_byte;
	logic [7:0]  address_index;
	logic [15:0] port;
	logic        reply_code;

	modport source (output valid, output event_res, output reply_method, output command,
		output address_type, output address_byte, output address_index, output port,
		output reply_code, input ready);
	modport sink (input valid, input event_res, input reply_method, input command,
		input address_type, input address_byte, input address_index, input port,
		input reply_code, output ready);
endinterface

@@ design/s5hp_cfg_if.sv @@
// Configuration write channel: register index and data with valid/ready.
// Depends on s5hp_pkg.
interface s5hp_cfg_if;
	import s5hp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/socks5_handshake_parser.sv @@
// SOCKS5 client greeting and request parser, one received byte per word.
// Depends on s5hp_pkg, s5hp_byte_if, s5hp_res_if and s5hp_cfg_if.
//
// Usage:
//   rx  : received bytes from the client connection, one per word.
//   res : exactly one result word per received byte, in order: the parse
//         event, the chosen reply method, captured command, address type and
//         reply code, streamed address bytes and the assembled port.
//   cfg : register writes (pref_count, pref_method_0..3), always ready; write
//         only while no byte is in flight.
// Path: each accepted byte passes the input register, then the state update and
// the result register. Throughput is one byte per cycle while res does not
// stall, limited by the single parse state register.
// When res stalls, the result register holds and the input register fills;
// rx.ready drops only once both are full, and follows res.ready after that.
// Reset returns the parser to the greeting version byte, clears captured
// values and in-flight words, and sets pref_count to 1 with all methods 0.
// After a close every further byte yields an ignored event.
module socks5_handshake_parser #(
	parameter int PREF_SLOTS = s5hp_pkg::PREF_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	s5hp_byte_if.sink   rx,
	s5hp_res_if.source  res,
	s5hp_cfg_if.sink    cfg
);
	import s5hp_pkg::*;

	localparam int NSLOT = (PREF_SLOTS < MAX_SLOTS) ? PREF_SLOTS : MAX_SLOTS;
	localparam logic [COUNT_W-1:0] NSLOT_C = COUNT_W'(NSLOT);

	typedef enum logic [3:0] {
		PH_VER, PH_NMETH, PH_METHODS, PH_HDR, PH_DLEN,
		PH_ADDR, PH_PORT_HI, PH_PORT_LO, PH_CLOSED
	} phase_t;

	// configuration
	logic [COUNT_W-1:0]  pref_count_q;
	logic [METHOD_W-1:0] pref_q [NSLOT];

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state
	phase_t         phase_q, phase_d;
	logic [7:0]     method_count_q, method_count_d;
	logic [NSLOT-1:0] mask_q, mask_d;
	logic [1:0]     hdr_idx_q, hdr_idx_d;
	logic [7:0]     cmd_q, cmd_d;
	logic [7:0]     atyp_q, atyp_d;
	logic           rcode_q, rcode_d;
	logic [7:0]     alen_q, alen_d;
	logic [7:0]     acnt_q, acnt_d;
	logic [7:0]     port_hi_q, port_hi_d;

	// result register
	logic        res_valid_q;
	event_t      ev_q, ev_d;
	logic [7:0]  rmeth_q, rmeth_d;
	logic [7:0]  abyte_q, abyte_d;
	logic [7:0]  aidx_q, aidx_d;
	logic [15:0] port_q, port_d;

	// captured fields go out with the values after this byte
	logic [7:0] cmd_out_q, atyp_out_q;
	logic       rcode_out_q;

	logic             out_free;
	logic             step;
	logic [COUNT_W-1:0] n_used;
	logic [NSLOT-1:0] hit;
	logic [NSLOT-1:0] new_mask;
	logic [7:0]       pick;
	logic [7:0]       cnt_dec;
	logic [7:0]       acnt_inc;

	assign out_free = !res_valid_q || res.ready;
	assign step     = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	assign n_used   = (pref_count_q > NSLOT_C) ? NSLOT_C : pref_count_q;
	assign cnt_dec  = method_count_q - 8'd1;
	assign acnt_inc = acnt_q + 8'd1;

	always_comb begin
		for (int i = 0; i < NSLOT; i++) begin
			hit[i] = (COUNT_W'(i) < n_used) && (byte_s1 == {4'h0, pref_q[i]});
		end
		new_mask = mask_q | hit;
		pick = NO_METHOD;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (new_mask[i] && (COUNT_W'(i) < n_used)) begin
				pick = {4'h0, pref_q[i]};
			end
		end
	end

	always_comb begin
		phase_d        = phase_q;
		method_count_d = method_count_q;
		mask_d         = mask_q;
		hdr_idx_d      = hdr_idx_q;
		cmd_d          = cmd_q;
		atyp_d         = atyp_q;
		rcode_d        = rcode_q;
		alen_d         = alen_q;
		acnt_d         = acnt_q;
		port_hi_d      = port_hi_q;
		ev_d           = EV_IGNORED;
		rmeth_d        = '0;
		abyte_d        = '0;
		aidx_d         = '0;
		port_d         = '0;
		case (phase_q)
			PH_VER: begin
				if (byte_s1 != SOCKS_VERSION) begin
					ev_d    = EV_BAD_VER;
					phase_d = PH_CLOSED;
				end else begin
					ev_d    = EV_CONSUMED;
					phase_d = PH_NMETH;
				end
			end
			PH_NMETH: begin
				method_count_d = byte_s1;
				mask_d         = '0;
				if (byte_s1 == 8'd0) begin
					ev_d    = EV_REFUSED;
					rmeth_d = NO_METHOD;
					phase_d = PH_CLOSED;
				end else begin
					ev_d    = EV_CONSUMED;
					phase_d = PH_METHODS;
				end
			end
			PH_METHODS: begin
				mask_d         = new_mask;
				method_count_d = cnt_dec;
				if (cnt_dec != 8'd0) begin
					ev_d = EV_CONSUMED;
				end else begin
					rmeth_d = pick;
					if (pick == NO_METHOD) begin
						ev_d    = EV_REFUSED;
						phase_d = PH_CLOSED;
					end else if (pick == METHOD_NOAUTH) begin
						ev_d      = EV_REPLY_CONT;
						hdr_idx_d = 2'd0;
						phase_d   = PH_HDR;
					end else begin
						ev_d    = EV_REPLY_CLOSE;
						phase_d = PH_CLOSED;
					end
				end
			end
			PH_HDR: begin
				ev_d      = EV_CONSUMED;
				hdr_idx_d = hdr_idx_q + 2'd1;
				case (hdr_idx_q)
					2'd0: rcode_d = (byte_s1 != SOCKS_VERSION);
					2'd1: cmd_d = byte_s1;
					2'd3: begin
						atyp_d = byte_s1;
						acnt_d = '0;
						if (byte_s1 == ATYP_IPV4) begin
							alen_d  = IPV4_LEN;
							phase_d = PH_ADDR;
						end else if (byte_s1 == ATYP_IPV6) begin
							alen_d  = IPV6_LEN;
							phase_d = PH_ADDR;
						end else if (byte_s1 == ATYP_DOMAIN) begin
							phase_d = PH_DLEN;
						end else begin
							ev_d    = EV_BAD_ATYP;
							phase_d = PH_CLOSED;
						end
					end
					default: ;
				endcase
			end
			PH_DLEN: begin
				ev_d    = EV_CONSUMED;
				alen_d  = byte_s1;
				acnt_d  = '0;
				phase_d = (byte_s1 == 8'd0) ? PH_PORT_HI : PH_ADDR;
			end
			PH_ADDR: begin
				ev_d    = EV_ADDR;
				abyte_d = byte_s1;
				aidx_d  = acnt_q;
				acnt_d  = acnt_inc;
				if (acnt_inc == alen_q) phase_d = PH_PORT_HI;
			end
			PH_PORT_HI: begin
				ev_d      = EV_CONSUMED;
				port_hi_d = byte_s1;
				phase_d   = PH_PORT_LO;
			end
			PH_PORT_LO: begin
				ev_d    = EV_DONE;
				port_d  = {port_hi_q, byte_s1};
				phase_d = PH_CLOSED;
			end
			default: begin
				ev_d    = EV_IGNORED;
				phase_d = PH_CLOSED;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_count_q <= COUNT_W'(1);
			for (int i = 0; i < NSLOT; i++) pref_q[i] <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_PREF_COUNT) pref_count_q <= cfg.data[COUNT_W-1:0];
			for (int i = 0; i < NSLOT; i++) begin
				if (cfg.index == REG_PREF_METHOD_0 + CFG_IDX_W'(i)) begin
					pref_q[i] <= cfg.data[METHOD_W-1:0];
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) byte_s1 <= rx.rx_byte;
	end

	// parse state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_VER;
			method_count_q <= '0;
			mask_q         <= '0;
			hdr_idx_q      <= '0;
			cmd_q          <= '0;
			atyp_q         <= '0;
			rcode_q        <= 1'b0;
			alen_q         <= '0;
			acnt_q         <= '0;
			port_hi_q      <= '0;
			res_valid_q    <= 1'b0;
			ev_q           <= EV_CONSUMED;
			rmeth_q        <= '0;
			abyte_q        <= '0;
			aidx_q         <= '0;
			port_q         <= '0;
			cmd_out_q      <= '0;
			atyp_out_q     <= '0;
			rcode_out_q    <= 1'b0;
		end else begin
			if (out_free) res_valid_q <= valid_s1;
			if (step) begin
				phase_q        <= phase_d;
				method_count_q <= method_count_d;
				mask_q         <= mask_d;
				hdr_idx_q      <= hdr_idx_d;
				cmd_q          <= cmd_d;
				atyp_q         <= atyp_d;
				rcode_q        <= rcode_d;
				alen_q         <= alen_d;
				acnt_q         <= acnt_d;
				port_hi_q      <= port_hi_d;
				ev_q           <= ev_d;
				rmeth_q        <= rmeth_d;
				abyte_q        <= abyte_d;
				aidx_q         <= aidx_d;
				port_q         <= port_d;
				cmd_out_q      <= cmd_d;
				atyp_out_q     <= atyp_d;
				rcode_out_q    <= rcode_d;
			end
		end
	end

	assign res.valid         = res_valid_q;
	assign res.event_res     = ev_q;
	assign res.reply_method  = rmeth_q;
	assign res.command       = cmd_out_q;
	assign res.address_type  = atyp_out_q;
	assign res.address_byte  = abyte_q;
	assign res.address_index = aidx_q;
	assign res.port          = port_q;
	assign res.reply_code    = rcode_out_q;

endmodule
